FILE: sv/idts_pkg.sv
// Shared types, constants and helpers for the identifier table block.
`timescale 1ns / 1ps

package idts_pkg;

  localparam int ID_W = 32;
  localparam int FUNC_W = 2;
  localparam int POS_W = 7;
  localparam int POS_MAX = 127;
  localparam int DEFAULT_TABLE_DEPTH = 128;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_SORT   = 2'd2,
    FUNC_SEARCH = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEY_RD,
    ST_KEY_LD,
    ST_SORT_CMP,
    ST_SORT_PUT,
    ST_SRCH_CHK,
    ST_SRCH_CMP,
    ST_DONE
  } state_t;

  function automatic logic [POS_W-1:0] sat_pos(input logic [31:0] v);
    logic [POS_W-1:0] r;
    if (v > 32'(POS_MAX)) begin
      r = POS_W'(POS_MAX);
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/id_table_sort_and_binary_search.sv
// Top level of the identifier table with in-place insertion sort and binary search.
`timescale 1ns / 1ps

// The table holds up to TABLE_DEPTH signed 32-bit identifiers in a single-port-read memory
// under a small sequencer; one transaction is taken at a time and in_ready is low while it
// runs. Clear and append go straight to the done state and present their result once the
// output register is free. Search halves the range on each probe, and every probe waits on
// the registered memory read. Sort reads each key and then shifts larger entries up one place
// at a time, so it is quadratic in the count in the worst case. A result waits in its own
// output register, and position saturates at 127.
module id_table_sort_and_binary_search #(
  parameter int TABLE_DEPTH = idts_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [idts_pkg::FUNC_W-1:0]         func,
  input  logic signed [idts_pkg::ID_W-1:0]    value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                found,
  output logic [idts_pkg::POS_W-1:0]          position,
  output logic                                status
);
  import idts_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t state, state_next;

  logic [ID_W-1:0]        mem [TABLE_DEPTH];
  logic signed [ID_W-1:0] rdata;
  logic signed [ID_W-1:0] key;
  logic [CW-1:0]          fill_count;
  logic [AW-1:0]          idx_i;
  logic [AW-1:0]          gap;
  logic [AW-1:0]          mid;
  logic [CW-1:0]          lo;
  logic [CW-1:0]          hi_ex;
  logic                   res_found;
  logic [POS_W-1:0]       res_pos;
  logic                   res_status;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [ID_W-1:0]        mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;

  logic                   rd_lt;
  logic                   rd_eq;
  logic                   key_lt;
  logic                   full;
  logic                   last_i;
  logic                   range_ok;
  logic [CW-1:0]          span;
  logic [CW-1:0]          mid_calc;
  logic                   out_free;

  assign rd_lt    = rdata < key;
  assign rd_eq    = rdata == key;
  assign key_lt   = !rd_lt && !rd_eq;
  assign full     = fill_count >= CW'(TABLE_DEPTH);
  assign last_i   = (CW'(idx_i) + CW'(1)) >= fill_count;
  assign range_ok = lo < hi_ex;
  assign span     = hi_ex - lo - CW'(1);
  assign mid_calc = lo + (span >> 1);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (func_t'(func))
            FUNC_CLEAR, FUNC_APPEND: state_next = ST_DONE;
            FUNC_SORT: state_next = (fill_count < CW'(2)) ? ST_DONE : ST_KEY_RD;
            FUNC_SEARCH: state_next = ST_SRCH_CHK;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_KEY_RD: state_next = ST_KEY_LD;
      ST_KEY_LD: state_next = ST_SORT_CMP;
      ST_SORT_CMP: begin
        if (key_lt) begin
          state_next = (gap == AW'(1)) ? ST_SORT_PUT : ST_SORT_CMP;
        end else begin
          state_next = last_i ? ST_DONE : ST_KEY_RD;
        end
      end
      ST_SORT_PUT: state_next = last_i ? ST_DONE : ST_KEY_RD;
      ST_SRCH_CHK: state_next = range_ok ? ST_SRCH_CMP : ST_DONE;
      ST_SRCH_CMP: state_next = rd_eq ? ST_DONE : ST_SRCH_CHK;
      ST_DONE: state_next = out_free ? ST_IDLE : ST_DONE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = gap;
    mem_wdata = key;
    mem_re    = 1'b0;
    mem_raddr = idx_i;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        mem_waddr = fill_count[AW-1:0];
        mem_wdata = value;
        mem_we    = in_valid && (func_t'(func) == FUNC_APPEND) && !full;
      end
      ST_KEY_RD: begin
        mem_re = 1'b1;
      end
      ST_KEY_LD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_i - AW'(1);
      end
      ST_SORT_CMP: begin
        mem_we = 1'b1;
        if (key_lt) begin
          mem_wdata = rdata;
          mem_re    = gap != AW'(1);
          mem_raddr = gap - AW'(2);
        end
      end
      ST_SORT_PUT: begin
        mem_we = 1'b1;
      end
      ST_SRCH_CHK: begin
        mem_re    = range_ok;
        mem_raddr = mid_calc[AW-1:0];
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            key        <= value;
            res_found  <= 1'b0;
            res_status <= 1'b0;
            case (func_t'(func))
              FUNC_CLEAR: begin
                fill_count <= '0;
                res_pos    <= '0;
              end
              FUNC_APPEND: begin
                if (full) begin
                  res_status <= 1'b1;
                  res_pos    <= sat_pos(32'(fill_count));
                end else begin
                  fill_count <= fill_count + CW'(1);
                  res_pos    <= sat_pos(32'(fill_count) + 32'd1);
                end
              end
              FUNC_SORT: begin
                res_pos <= sat_pos(32'(fill_count));
                idx_i   <= AW'(1);
              end
              default: begin
                res_pos <= '0;
                lo      <= '0;
                hi_ex   <= fill_count;
              end
            endcase
          end
        end
        ST_KEY_LD: begin
          key <= rdata;
          gap <= idx_i;
        end
        ST_SORT_CMP: begin
          if (key_lt) begin
            gap <= gap - AW'(1);
          end else begin
            idx_i <= idx_i + AW'(1);
          end
        end
        ST_SORT_PUT: begin
          idx_i <= idx_i + AW'(1);
        end
        ST_SRCH_CHK: begin
          mid <= mid_calc[AW-1:0];
        end
        ST_SRCH_CMP: begin
          if (rd_eq) begin
            res_found <= 1'b1;
            res_pos   <= sat_pos(32'(mid));
          end else if (rd_lt) begin
            lo <= CW'(mid) + CW'(1);
          end else begin
            hi_ex <= CW'(mid);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            found     <= res_found;
            position  <= res_pos;
            status    <= res_status;
          end
        end
        default: begin
          lo <= lo;
        end
      endcase
    end
  end

endmodule

FILE: sv/idts_checker.sv
// Port-level checker for the identifier table block and its bind statement.
`timescale 1ns / 1ps

module idts_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [idts_pkg::FUNC_W-1:0]      func,
  input logic [idts_pkg::ID_W-1:0]        value,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             found,
  input logic [idts_pkg::POS_W-1:0]       position,
  input logic                             status
);

  // An accepted transaction keeps in_ready low in the cycle after acceptance.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again in the cycle after acceptance");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(position)
      && $stable(status))
    else $error("stalled result changed");

  a_found_not_dropped: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> !status)
    else $error("hit reported together with a dropped append");

  // A dropped append only happens on a full table, so its count is never zero.
  a_drop_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> position != '0)
    else $error("dropped append reported an empty table");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(func) && $stable(value))
    else $error("stalled input transaction changed");

endmodule

bind id_table_sort_and_binary_search idts_checker u_idts_checker (.*);
